// File: sv/ccint_pkg.sv
`timescale 1ns / 1ps
package ccint_pkg;
  // default geometry
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  // fixed field widths
  localparam int RAD_WIDTH  = 16;
  localparam int DIST_WIDTH = 36;
endpackage

// File: sv/ccint_div.sv
`timescale 1ns / 1ps
// Pipelined clamped fraction: quot = clamp(num/den) in Q1.FB, one quotient bit per stage.
module ccint_div #(
  parameter int W  = 72,
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_valid,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [FB:0]         quot,
  output logic [SW-1:0]       out_side
);
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  logic [FB:0]   v_r;
  logic [FB:0]   fix_r;
  logic [W-1:0]  rem_r  [FB+1];
  logic [W-1:0]  den_r  [FB+1];
  logic [FB:0]   q_r    [FB+1];
  logic [SW-1:0] side_r [FB+1];

  logic n_le0, n_ge;
  assign n_le0 = num[W-1] || (num == '0);
  assign n_ge  = (num >= den);

  // setup: catch out-of-range ratios
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fix_r[0]  <= n_le0 || n_ge;
      q_r[0]    <= n_le0 ? '0 : (n_ge ? ONE : '0);
      rem_r[0]  <= num;
      den_r[0]  <= den;
      side_r[0] <= in_side;
    end
  end

  // restoring steps
  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [W-1:0] sh;
    logic         ge;
    assign sh = {rem_r[k-1][W-2:0], 1'b0};
    assign ge = (sh >= den_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        fix_r[k]  <= fix_r[k-1];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
        if (fix_r[k-1]) begin
          rem_r[k] <= rem_r[k-1];
          q_r[k]   <= q_r[k-1];
        end else begin
          rem_r[k] <= ge ? (sh - den_r[k-1]) : sh;
          q_r[k]   <= {q_r[k-1][FB-1:0], ge};
        end
      end
    end
  end

  assign out_valid = v_r[FB];
  assign quot      = q_r[FB];
  assign out_side  = side_r[FB];
endmodule

// File: sv/ccint_front.sv
`timescale 1ns / 1ps
// Front end: deltas, dot products, determinant and first ratio operands.
module ccint_front #(
  parameter int CW = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic [3*CW-1:0]                seg1_start,
  input  logic [3*CW-1:0]                seg1_end,
  input  logic [ccint_pkg::RAD_WIDTH-1:0] radius1,
  input  logic [3*CW-1:0]                seg2_start,
  input  logic [3*CW-1:0]                seg2_end,
  input  logic [ccint_pkg::RAD_WIDTH-1:0] radius2,
  output logic                           out_valid,
  output logic signed [4*CW+8:0]         num,
  output logic signed [4*CW+8:0]         den,
  output logic [22*CW+ccint_pkg::RAD_WIDTH+28:0] side
);
  import ccint_pkg::*;

  localparam int LW = CW + 1;
  localparam int PW = 2 * LW;
  localparam int AW = 2 * CW + 4;
  localparam int W1 = 4 * CW + 9;
  localparam int GW = 6 * CW + 6 * LW + RAD_WIDTH + 1;

  logic signed [CW-1:0] a1 [3], b1 [3], a2 [3], b2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a1[i] = seg1_start[i*CW +: CW];
      b1[i] = seg1_end[i*CW +: CW];
      a2[i] = seg2_start[i*CW +: CW];
      b2[i] = seg2_end[i*CW +: CW];
    end
  end

  // stage 1: lane deltas
  logic                 v1_r;
  logic signed [CW-1:0] p1_r [3], p2_r [3];
  logic signed [LW-1:0] d1_r [3], d2_r [3], r_r [3];
  logic [RAD_WIDTH:0]   rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (ce) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= a1[i];
        p2_r[i] <= a2[i];
        d1_r[i] <= LW'(b1[i]) - LW'(a1[i]);
        d2_r[i] <= LW'(b2[i]) - LW'(a2[i]);
        r_r[i]  <= LW'(a1[i]) - LW'(a2[i]);
      end
      rs_r <= {1'b0, radius1} + {1'b0, radius2};
    end
  end

  logic [GW-1:0] geo1;
  always_comb begin
    geo1 = {rs_r, d2_r[2], d2_r[1], d2_r[0], d1_r[2], d1_r[1], d1_r[0],
            p2_r[2], p2_r[1], p2_r[0], p1_r[2], p1_r[1], p1_r[0]};
  end

  // stage 2: lane products
  logic                 v2_r;
  logic signed [PW-1:0] paa_r [3], pee_r [3], pff_r [3], pcc_r [3], pbb_r [3];
  logic [GW-1:0]        geo2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (ce) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        paa_r[i] <= PW'(d1_r[i]) * PW'(d1_r[i]);
        pee_r[i] <= PW'(d2_r[i]) * PW'(d2_r[i]);
        pff_r[i] <= PW'(d2_r[i]) * PW'(r_r[i]);
        pcc_r[i] <= PW'(d1_r[i]) * PW'(r_r[i]);
        pbb_r[i] <= PW'(d1_r[i]) * PW'(d2_r[i]);
      end
      geo2_r <= geo1;
    end
  end

  // stage 3: dot products
  logic                 v3_r, az3_r, ez3_r;
  logic signed [AW-1:0] a3_r, e3_r, f3_r, c3_r, b3_r;
  logic [GW-1:0]        geo3_r;
  logic signed [AW-1:0] a3, e3;

  assign a3 = AW'(paa_r[0]) + AW'(paa_r[1]) + AW'(paa_r[2]);
  assign e3 = AW'(pee_r[0]) + AW'(pee_r[1]) + AW'(pee_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (ce) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a3_r   <= a3;
      e3_r   <= e3;
      az3_r  <= (a3 == '0);
      ez3_r  <= (e3 == '0);
      f3_r   <= AW'(pff_r[0]) + AW'(pff_r[1]) + AW'(pff_r[2]);
      c3_r   <= AW'(pcc_r[0]) + AW'(pcc_r[1]) + AW'(pcc_r[2]);
      b3_r   <= AW'(pbb_r[0]) + AW'(pbb_r[1]) + AW'(pbb_r[2]);
      geo3_r <= geo2_r;
    end
  end

  // stage 4: cross products
  logic                 v4_r, az4_r, ez4_r;
  logic signed [W1-1:0] ae_r, bb_r, bf_r, ce_r;
  logic signed [AW-1:0] a4_r, e4_r, f4_r, c4_r, b4_r;
  logic [GW-1:0]        geo4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (ce) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ae_r   <= W1'(a3_r) * W1'(e3_r);
      bb_r   <= W1'(b3_r) * W1'(b3_r);
      bf_r   <= W1'(b3_r) * W1'(f3_r);
      ce_r   <= W1'(c3_r) * W1'(e3_r);
      a4_r   <= a3_r;
      e4_r   <= e3_r;
      f4_r   <= f3_r;
      c4_r   <= c3_r;
      b4_r   <= b3_r;
      az4_r  <= az3_r;
      ez4_r  <= ez3_r;
      geo4_r <= geo3_r;
    end
  end

  // stage 5: pick operands of the first ratio
  logic                 v5_r;
  logic signed [W1-1:0] num_r, den_r;
  logic signed [W1-1:0] det, snum, n5, d5;
  logic [GW+5*AW+1:0]   side_r;

  assign det  = ae_r - bb_r;
  assign snum = bf_r - ce_r;

  always_comb begin
    if (az4_r) begin
      n5 = '0;
      d5 = W1'(1);
    end else if (ez4_r) begin
      n5 = -W1'(c4_r);
      d5 = W1'(a4_r);
    end else if (det != '0) begin
      n5 = snum;
      d5 = det;
    end else begin
      n5 = '0;
      d5 = W1'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (ce) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num_r  <= n5;
      den_r  <= d5;
      side_r <= {ez4_r, az4_r, f4_r, e4_r, c4_r, b4_r, a4_r, geo4_r};
    end
  end

  assign out_valid = v5_r;
  assign num       = num_r;
  assign den       = den_r;
  assign side      = side_r;
endmodule

// File: sv/ccint_back.sv
`timescale 1ns / 1ps
// Back end: closest points, squared distance and radius test.
module ccint_back #(
  parameter int CW = 16,
  parameter int FB = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ce,
  input  logic                                  in_valid,
  input  logic [FB:0]                           s_in,
  input  logic [FB:0]                           t_in,
  input  logic [12*CW+6+ccint_pkg::RAD_WIDTH:0] geo,
  output logic                                  out_valid,
  output logic                                  hit,
  output logic [ccint_pkg::DIST_WIDTH-1:0]      dist_sq,
  output logic [FB:0]                           s_param,
  output logic [FB:0]                           t_param,
  output logic [3*CW-1:0]                       closest1,
  output logic [3*CW-1:0]                       closest2
);
  import ccint_pkg::*;

  localparam int LW   = CW + 1;
  localparam int MW   = CW + FB + 3;
  localparam int DW   = CW + FB + 5;
  localparam int SUMW = 2 * CW + 2 * FB + 26;
  localparam int RQW  = 2 * (RAD_WIDTH + 1);

  logic signed [CW-1:0] p1 [3], p2 [3];
  logic signed [LW-1:0] d1 [3], d2 [3];
  logic [RAD_WIDTH:0]   rs;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1[i] = geo[i*CW +: CW];
      p2[i] = geo[3*CW + i*CW +: CW];
      d1[i] = geo[6*CW + i*LW +: LW];
      d2[i] = geo[6*CW + 3*LW + i*LW +: LW];
    end
    rs = geo[6*CW + 6*LW +: RAD_WIDTH+1];
  end

  // stage 1: scaled deltas
  logic                 v1_r;
  logic signed [MW-1:0] m1_r [3], m2_r [3];
  logic signed [LW-1:0] r1_r [3];
  logic signed [CW-1:0] p1_r [3], p2_r [3];
  logic [RAD_WIDTH:0]   rs1_r;
  logic [FB:0]          s1_r, t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (ce) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= MW'(d1[i]) * MW'($signed({1'b0, s_in}));
        m2_r[i] <= MW'(d2[i]) * MW'($signed({1'b0, t_in}));
        r1_r[i] <= LW'(p1[i]) - LW'(p2[i]);
        p1_r[i] <= p1[i];
        p2_r[i] <= p2[i];
      end
      rs1_r <= rs;
      s1_r  <= s_in;
      t1_r  <= t_in;
    end
  end

  // stage 2: lane differences and points
  logic                 v2_r;
  logic signed [DW-1:0] df_r [3];
  logic [3*CW-1:0]      c1_2_r, c2_2_r;
  logic [RQW-1:0]       rq_r;
  logic [FB:0]          s2_r, t2_r;
  logic [3*CW-1:0]      c1_nxt, c2_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_nxt[i*CW +: CW] = p1_r[i] + CW'(m1_r[i] >>> FB);
      c2_nxt[i*CW +: CW] = p2_r[i] + CW'(m2_r[i] >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (ce) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        df_r[i] <= (DW'(r1_r[i]) <<< FB) + DW'(m1_r[i]) - DW'(m2_r[i]);
      end
      c1_2_r <= c1_nxt;
      c2_2_r <= c2_nxt;
      rq_r   <= RQW'(rs1_r) * RQW'(rs1_r);
      s2_r   <= s1_r;
      t2_r   <= t1_r;
    end
  end

  // stage 3: squares
  logic                v3_r;
  logic [2*DW-1:0]     sq_r [3];
  logic [SUMW-1:0]     rad_r;
  logic [3*CW-1:0]     c1_3_r, c2_3_r;
  logic [FB:0]         s3_r, t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (ce) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (2*DW)'(df_r[i]) * (2*DW)'(df_r[i]);
      end
      rad_r  <= SUMW'(rq_r) << (2 * FB);
      c1_3_r <= c1_2_r;
      c2_3_r <= c2_2_r;
      s3_r   <= s2_r;
      t3_r   <= t2_r;
    end
  end

  // stage 4: sum, compare, saturate into the output register
  logic                  v4_r, hit_r;
  logic [DIST_WIDTH-1:0] dist_r;
  logic [3*CW-1:0]       c1_4_r, c2_4_r;
  logic [FB:0]           s4_r, t4_r;
  logic [SUMW-1:0]       sum;

  assign sum = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (ce) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hit_r  <= (sum <= rad_r);
      dist_r <= (|sum[SUMW-1:2*FB+DIST_WIDTH]) ? '1 : sum[2*FB +: DIST_WIDTH];
      c1_4_r <= c1_3_r;
      c2_4_r <= c2_3_r;
      s4_r   <= s3_r;
      t4_r   <= t3_r;
    end
  end

  assign out_valid = v4_r;
  assign hit       = hit_r;
  assign dist_sq   = dist_r;
  assign s_param   = s4_r;
  assign t_param   = t4_r;
  assign closest1  = c1_4_r;
  assign closest2  = c2_4_r;
endmodule

// File: sv/capsule_capsule_intersect.sv
`timescale 1ns / 1ps
// Capsule pair overlap test.
// in_tdata carries one request: two capsules, each two segment endpoints
// (x,y,z signed lanes) and a radius. out_tdata returns the clamped closest
// point parameters s and t (Q1.FRAC_BITS), both closest points, the squared
// distance floored to whole units and saturated, and a hit flag set when the
// distance does not exceed the sum of the radii.
// Throughput: one request per clock while the output is not stalled. The path from
// acceptance to out_tvalid runs through 5 front-end stages, the s quotient pipeline
// (FRAC_BITS+1 stages), one b*s stage, the t quotient pipeline (FRAC_BITS+1
// stages, with the s re-solve running beside it) and 4 back-end stages.
// The pipeline advances whenever the output register is empty or being
// taken; while out_tvalid is high and out_tready low every stage holds and
// in_tready is low, so nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; no state survives
// between requests.
module capsule_capsule_intersect #(
  parameter int COORD_WIDTH = ccint_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ccint_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // seg1_start, seg1_end, radius1, seg2_start, seg2_end, radius2, zero pad
  input  logic [((12*COORD_WIDTH+2*ccint_pkg::RAD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hit, dist_sq, s_param, t_param, closest1, closest2, zero pad
  output logic [((1+ccint_pkg::DIST_WIDTH+2*(FRAC_BITS+1)+6*COORD_WIDTH+7)/8)*8-1:0]
               out_tdata
);
  import ccint_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int LW   = CW + 1;
  localparam int AW   = 2 * CW + 4;
  localparam int W1   = 4 * CW + 9;
  localparam int TW   = AW + FB + 2;
  localparam int W3   = AW + 1;
  localparam int GW   = 6 * CW + 6 * LW + RAD_WIDTH + 1;
  localparam int SW1  = GW + 5 * AW + 2;
  localparam int SW2  = GW + FB + 1;
  localparam int OUTW = $bits(out_tdata);

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  // front end
  logic                 f_valid;
  logic signed [W1-1:0] f_num, f_den;
  logic [SW1-1:0]       f_side;

  ccint_front #(.CW(CW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (in_tvalid),
    .seg1_start (in_tdata[0 +: 3*CW]),
    .seg1_end   (in_tdata[3*CW +: 3*CW]),
    .radius1    (in_tdata[6*CW +: RAD_WIDTH]),
    .seg2_start (in_tdata[6*CW+RAD_WIDTH +: 3*CW]),
    .seg2_end   (in_tdata[9*CW+RAD_WIDTH +: 3*CW]),
    .radius2    (in_tdata[12*CW+RAD_WIDTH +: RAD_WIDTH]),
    .out_valid  (f_valid),
    .num        (f_num),
    .den        (f_den),
    .side       (f_side)
  );

  // first ratio: s
  logic           s_valid;
  logic [FB:0]    s0;
  logic [SW1-1:0] s_side;

  ccint_div #(.W(W1), .FB(FB), .SW(SW1)) u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .in_side   (f_side),
    .out_valid (s_valid),
    .quot      (s0),
    .out_side  (s_side)
  );

  // b*s for the t numerator
  logic                 m_valid_r;
  logic signed [TW-1:0] bs_r;
  logic [FB:0]          ms_r;
  logic [SW1-1:0]       mside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_valid_r <= 1'b0;
    else if (ce) m_valid_r <= s_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bs_r    <= TW'($signed(s_side[GW+AW +: AW])) * TW'($signed({1'b0, s0}));
      ms_r    <= s0;
      mside_r <= s_side;
    end
  end

  logic [GW-1:0]        m_geo;
  logic signed [AW-1:0] m_a, m_b, m_c, m_e, m_f;
  logic                 m_az, m_ez;
  assign m_geo = mside_r[0 +: GW];
  assign m_a   = mside_r[GW +: AW];
  assign m_b   = mside_r[GW+AW +: AW];
  assign m_c   = mside_r[GW+2*AW +: AW];
  assign m_e   = mside_r[GW+3*AW +: AW];
  assign m_f   = mside_r[GW+4*AW +: AW];
  assign m_az  = mside_r[GW+5*AW];
  assign m_ez  = mside_r[GW+5*AW+1];

  // t operands and the s re-solve for an out-of-range t
  logic signed [TW-1:0] tn, td, n2, d2;
  logic signed [W3-1:0] n3, d3;
  logic                 gen, t_neg, t_big, redo;

  assign tn    = bs_r + (TW'(m_f) <<< FB);
  assign td    = TW'(m_e) <<< FB;
  assign gen   = !m_az && !m_ez;
  assign t_neg = tn[TW-1];
  assign t_big = (tn > td);
  assign redo  = gen && (t_neg || t_big);

  always_comb begin
    if (m_ez) begin
      n2 = '0;
      d2 = TW'(1);
    end else begin
      n2 = tn;
      d2 = td;
    end
    if (gen && t_neg) begin
      n3 = -W3'(m_c);
      d3 = W3'(m_a);
    end else if (gen && t_big) begin
      n3 = W3'(m_b) - W3'(m_c);
      d3 = W3'(m_a);
    end else begin
      n3 = '0;
      d3 = W3'(1);
    end
  end

  logic           t_valid, r_valid;
  logic [FB:0]    t_q, s_q;
  logic [SW2-1:0] t_side;
  logic           r_redo;

  ccint_div #(.W(TW), .FB(FB), .SW(SW2)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (m_valid_r),
    .num       (n2),
    .den       (d2),
    .in_side   ({ms_r, m_geo}),
    .out_valid (t_valid),
    .quot      (t_q),
    .out_side  (t_side)
  );

  ccint_div #(.W(W3), .FB(FB), .SW(1)) u_div_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (m_valid_r),
    .num       (n3),
    .den       (d3),
    .in_side   (redo),
    .out_valid (r_valid),
    .quot      (s_q),
    .out_side  (r_redo)
  );

  logic [FB:0] s_fin;
  assign s_fin = r_redo ? s_q : t_side[GW +: FB+1];

  // back end
  logic                  o_hit;
  logic [DIST_WIDTH-1:0] o_dist;
  logic [FB:0]           o_s, o_t;
  logic [3*CW-1:0]       o_c1, o_c2;

  ccint_back #(.CW(CW), .FB(FB)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (t_valid && r_valid),
    .s_in      (s_fin),
    .t_in      (t_q),
    .geo       (t_side[0 +: GW]),
    .out_valid (out_tvalid),
    .hit       (o_hit),
    .dist_sq   (o_dist),
    .s_param   (o_s),
    .t_param   (o_t),
    .closest1  (o_c1),
    .closest2  (o_c2)
  );

  assign out_tdata = OUTW'({o_c2, o_c1, o_t, o_s, o_dist, o_hit});
endmodule

// File: tb/capsule_checker.sv
`timescale 1ns / 1ps
module capsule_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [223:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  output int           errors,
  output int           pending,
  output int           checked,
  output int           hits
);
  localparam int CW   = ccint_pkg::COORD_WIDTH_DEF;
  localparam int FB   = ccint_pkg::FRAC_BITS_DEF;
  localparam int DW   = ccint_pkg::DIST_WIDTH;
  localparam int RW   = ccint_pkg::RAD_WIDTH;
  localparam logic signed [127:0] ONE_Q = 128'sd1 <<< FB;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [3*CW-1:0] closest2;
    logic [3*CW-1:0] closest1;
    logic [FB:0]     t_param;
    logic [FB:0]     s_param;
    logic [DW-1:0]   dist_sq;
    logic            hit;
  } verdict_t;

  verdict_t expected_q[$];

  // clamped n/d in Q1.FB, floored; d > 0
  function automatic logic [FB:0] clamp_q(input wide_t n, input wide_t d);
    wide_t q;
    if (n <= 0) return '0;
    if (n >= d) return ONE_Q[FB:0];
    q = (n <<< FB) / d;
    return q[FB:0];
  endfunction

  function automatic verdict_t capsule_pair(input logic [223:0] req);
    wide_t p1[3], p2[3], d1[3], d2[3], rv[3];
    wide_t a, e, f, c, b, den, tn, td, s, t, m1, m2, diff, sum, rs, rad, ds;
    verdict_t v;
    a = 0; e = 0; f = 0; c = 0; b = 0; s = 0; t = 0; sum = 0;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      p1[i] = $signed(req[i*CW +: CW]);
      d1[i] = wide_t'($signed(req[48 + i*CW +: CW])) - p1[i];
      p2[i] = $signed(req[112 + i*CW +: CW]);
      d2[i] = wide_t'($signed(req[160 + i*CW +: CW])) - p2[i];
      rv[i] = p1[i] - p2[i];
      a += d1[i] * d1[i];
      e += d2[i] * d2[i];
      f += d2[i] * rv[i];
      c += d1[i] * rv[i];
      b += d1[i] * d2[i];
    end
    // degenerate segments first, then the general solve
    if (a == 0 && e == 0) begin
      s = 0; t = 0;
    end else if (a == 0) begin
      s = 0;
      t = clamp_q(f, e);
    end else if (e == 0) begin
      t = 0;
      s = clamp_q(-c, a);
    end else begin
      den = a * e - b * b;
      s = (den != 0) ? clamp_q(b * f - c * e, den) : 0;
      tn = b * s + (f <<< FB);
      td = e <<< FB;
      if (tn < 0) begin
        t = 0;
        s = clamp_q(-c, a);
      end else if (tn > td) begin
        t = ONE_Q;
        s = clamp_q(b - c, a);
      end else begin
        t = clamp_q(tn, td);
      end
    end
    for (int i = 0; i < 3; i++) begin
      m1 = d1[i] * s;
      m2 = d2[i] * t;
      diff = rv[i] * ONE_Q + m1 - m2;
      v.closest1[i*CW +: CW] = (p1[i] + (m1 >>> FB)) & ((128'sd1 <<< CW) - 1);
      v.closest2[i*CW +: CW] = (p2[i] + (m2 >>> FB)) & ((128'sd1 <<< CW) - 1);
      sum += diff * diff;
    end
    rs = wide_t'(req[96 +: RW]) + wide_t'(req[208 +: RW]);
    rad = (rs * rs) <<< (2 * FB);
    ds = sum >>> (2 * FB);
    v.hit = (rad < sum) ? 1'b0 : 1'b1;
    v.dist_sq = (ds > ((128'sd1 <<< DW) - 1)) ? '1 : ds[DW-1:0];
    v.s_param = s[FB:0];
    v.t_param = t[FB:0];
    return v;
  endfunction

  task automatic flag(input string what, input logic [63:0] exp_v, input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("MISMATCH %s: expected %h got %h (result %0d)", what, exp_v, got, checked);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    hits = 0;
  end

  // predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_q.push_back(capsule_pair(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[166:0];
        if (expected_q.size() == 0) begin
          flag("unexpected result", '0, got.dist_sq);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) flag("hit", want.hit, got.hit);
          if (got.dist_sq !== want.dist_sq) flag("dist_sq", want.dist_sq, got.dist_sq);
          if (got.s_param !== want.s_param) flag("s_param", want.s_param, got.s_param);
          if (got.t_param !== want.t_param) flag("t_param", want.t_param, got.t_param);
          if (got.closest1 !== want.closest1) flag("closest1", want.closest1, got.closest1);
          if (got.closest2 !== want.closest2) flag("closest2", want.closest2, got.closest2);
          if (want.hit) hits++;
        end
        checked++;
      end
      pending = expected_q.size();
    end
  end
endmodule

// File: tb/tb_capsule_capsule_intersect.sv
`timescale 1ns / 1ps
module tb_capsule_capsule_intersect;
  localparam int RAND_ITEMS = 1580;
  localparam int CYCLE_LIMIT = 2000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;
  int           errors, pending, checked, hits;
  int           cycles;
  int           burst_left;
  int           stall_mode, stall_left;

  capsule_capsule_intersect uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  capsule_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending), .checked(checked), .hits(hits)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cycles = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: randomly chosen stall patterns
  initial begin
    stall_mode = 0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 9) != 0);
      default: out_tready <= (cycles % 7 < 2);
    endcase
  end

  function automatic logic [47:0] point(input int x, input int y, input int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [47:0] near_point(input int span);
    int x, y, z;
    x = int'($urandom_range(0, 2 * span)) - span;
    y = int'($urandom_range(0, 2 * span)) - span;
    z = int'($urandom_range(0, 2 * span)) - span;
    return point(x, y, z);
  endfunction

  function automatic logic [223:0] capsules(input logic [47:0] a1, input logic [47:0] b1,
                                            input logic [15:0] r1, input logic [47:0] a2,
                                            input logic [47:0] b2, input logic [15:0] r2);
    return {r2, b2, a2, r1, b1, a1};
  endfunction

  // one request; holds tvalid and waits for acceptance
  task automatic push_request(input logic [223:0] req);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int wait_cycles, span;
    logic [47:0] a1, b1;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate, parallel, clamping, extremes
    push_request('0);
    push_request(capsules(point(5, 5, 5), point(5, 5, 5), 3,
                          point(9, 5, 5), point(9, 5, 5), 1));
    push_request(capsules(point(0, 3, 0), point(0, 3, 0), 2,
                          point(-10, 0, 0), point(10, 0, 0), 1));
    push_request(capsules(point(-10, 0, 0), point(10, 0, 0), 1,
                          point(0, 3, 0), point(0, 3, 0), 2));
    push_request(capsules(point(0, 0, 0), point(100, 0, 0), 4,
                          point(0, 5, 0), point(100, 5, 0), 1));
    push_request(capsules(point(0, 0, 0), point(100, 0, 0), 1,
                          point(200, 5, 0), point(300, 5, 0), 1));
    push_request(capsules(point(-50, 0, 0), point(50, 0, 0), 2,
                          point(0, -50, 7), point(0, 50, 7), 5));
    push_request(capsules(point(0, 0, 0), point(10, 0, 0), 1,
                          point(-30, 20, 0), point(-20, 40, 0), 1));
    push_request(capsules(point(0, 0, 0), point(10, 0, 0), 1,
                          point(30, 20, 0), point(20, 40, 0), 1));
    push_request(capsules(point(0, 0, 0), point(10, 0, 0), 1,
                          point(5, 3, 0), point(5, 40, 0), 1));
    push_request(capsules(point(0, 0, 0), point(10, 0, 0), 1,
                          point(5, -40, 0), point(5, -3, 0), 1));
    push_request(capsules(point(32767, 32767, 32767), point(-32768, -32768, -32768), 16'hffff,
                          point(-32768, 32767, -32768), point(32767, -32768, 32767), 16'hffff));
    push_request(capsules(point(32767, 32767, 32767), point(32767, 32767, 32767), 0,
                          point(-32768, -32768, -32768), point(-32768, -32768, -32768), 0));
    push_request(capsules(point(-32768, -32768, -32768), point(32767, 32767, 32767), 16'hffff,
                          point(-32768, -32767, -32768), point(32767, 32768, 32767), 0));
    push_request(capsules(point(0, 0, 0), point(3, 4, 0), 0,
                          point(0, 0, 0), point(-3, 4, 0), 0));
    push_request(capsules(point(0, 0, 0), point(0, 0, 10), 2,
                          point(4, 0, 5), point(4, 0, 5), 2));
    push_request(capsules(point(0, 0, 0), point(0, 0, 10), 1,
                          point(4, 0, 5), point(4, 0, 5), 2));
    push_request({224{1'b1}});

    // random: mostly nearby capsules of mixed size, some fully random
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1: push_request(capsules(48'({$urandom(), $urandom()}),
                                    48'({$urandom(), $urandom()}), 16'($urandom()),
                                    48'({$urandom(), $urandom()}),
                                    48'({$urandom(), $urandom()}), 16'($urandom())));
        2: begin
          a1 = near_point(200);
          b1 = ($urandom_range(0, 1) == 1) ? a1 : near_point(200);
          push_request(capsules(a1, b1, 16'($urandom_range(0, 40)),
                                near_point(200), near_point(200),
                                16'($urandom_range(0, 40))));
        end
        3: begin
          a1 = near_point(100);
          push_request(capsules(near_point(100), near_point(100), 16'($urandom_range(0, 30)),
                                a1, a1, 16'($urandom_range(0, 30))));
        end
        default: begin
          span = ($urandom_range(0, 3) == 0) ? 30000 : 500;
          push_request(capsules(near_point(span), near_point(span),
                                16'($urandom_range(0, span / 4)),
                                near_point(span), near_point(span),
                                16'($urandom_range(0, span / 4))));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // drain and let the pipeline settle
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);

    $display("Checked %0d capsule pairs (%0d hits): degenerate, parallel, clamped, extremes",
             checked, hits);
    $display("and random pairs under bursty input and varied output stalls.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
